### hdl/archimedean_spiral_point_generator_macros.svh
// Assertion helpers for the spiral generator RTL.
`ifndef ARCHIMEDEAN_SPIRAL_POINT_GENERATOR_MACROS_SVH
`define ARCHIMEDEAN_SPIRAL_POINT_GENERATOR_MACROS_SVH

// Same-cycle implication, sampled on clk_i, idle while rst_ni is low.
`define ASP_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, idle while rst_ni is low.
`define ASP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/asp_pkg.sv
package asp_pkg;

  localparam int unsigned MAX_POINTS_DEF    = 1024;
  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned ROM_STAGES        = 32;

  localparam int unsigned IDX_W     = 10;
  localparam int unsigned IDX_MAX   = (1 << IDX_W) - 1;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned TH16_W    = 26;   // index * step, Q.16 radians
  localparam int unsigned TW        = 42;   // angle in Q.32
  localparam int unsigned R31_W     = 43;   // radius in Q.31
  localparam int unsigned R16_W     = R31_W - 15;
  localparam int unsigned PROD_W    = 60;   // gain * radius
  localparam int unsigned XW        = 38;   // CORDIC x / y, Q.24
  localparam int unsigned ZW        = 37;   // CORDIC residual angle, Q.32
  localparam int unsigned OUT_W     = 24;
  localparam int unsigned SH_W      = XW - 7; // rounded Q.16 before saturation
  localparam int unsigned RED_STEPS = 8;    // angle < 2^(IDX_W) rad, 2*pi*2^7 < that

  localparam logic signed [CFG_W-1:0] OFFSET_RST = 16'sd1638;
  localparam logic signed [CFG_W-1:0] PITCH_RST  = 16'sd1638;
  localparam logic [CFG_W-1:0]        STEP_RST   = 16'd6554;

  typedef enum logic [1:0] {
    REG_OFFSET = 2'd0,
    REG_PITCH  = 2'd1,
    REG_STEP   = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [TW-1:0]        z;
    logic signed [XW-1:0] x0;
  } red_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 neg;
  } cord_t;

  // Shift-subtract division, evaluated only on constants.
  function automatic logic [63:0] sp_udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(1/n) in Q.60 by its alternating series.
  function automatic logic [63:0] sp_atan_recip_q60(input logic [63:0] n);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] kk;
    logic [63:0] t;
    logic        add;
    p   = sp_udiv(64'd1 << 60, n);
    sum = '0;
    kk  = 64'd1;
    add = 1'b1;
    for (int i = 0; i < 48; i++) begin
      if (p != '0) begin
        t   = sp_udiv(p, kk);
        sum = add ? sum + t : sum - t;
        add = !add;
        kk  = kk + 64'd2;
        p   = sp_udiv(p, n * n);
      end
    end
    return sum;
  endfunction

  function automatic logic [63:0] sp_pi4_q60();
    return 64'd4 * sp_atan_recip_q60(64'd5) - sp_atan_recip_q60(64'd239);
  endfunction

  localparam logic [63:0] PI4_Q60     = sp_pi4_q60();
  localparam logic [63:0] TWO_PI_Q32  = (PI4_Q60 + (64'd1 << 24)) >> 25;
  localparam logic [63:0] PI_Q32      = (PI4_Q60 + (64'd1 << 25)) >> 26;
  localparam logic [63:0] HALF_PI_Q32 = (PI4_Q60 + (64'd1 << 26)) >> 27;

  // atan(2^-k) in Q.32.
  function automatic logic [63:0] sp_atan_q32(input int unsigned k);
    logic [63:0] sum;
    logic        add;
    sum = '0;
    add = 1'b1;
    if (k == 0) begin
      sum = PI4_Q60;
    end else begin
      for (int unsigned m = 1; m <= 61; m += 2) begin
        if (m * k <= 60) begin
          sum = add ? sum + sp_udiv(64'd1 << (60 - m * k), 64'(m))
                    : sum - sp_udiv(64'd1 << (60 - m * k), 64'(m));
          add = !add;
        end
      end
    end
    return (sum + (64'd1 << 27)) >> 28;
  endfunction

  function automatic logic [63:0] sp_isqrt(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bits;
    v    = val;
    res  = '0;
    bits = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bits > v) bits = bits >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bits != '0) begin
        if (v >= res + bits) begin
          v   = v - (res + bits);
          res = (res >> 1) + bits;
        end else begin
          res = res >> 1;
        end
        bits = bits >> 2;
      end
    end
    return res;
  endfunction

  // Inverse CORDIC gain for the given stage count, Q.31.
  function automatic logic [63:0] sp_gain_q31(input int unsigned stages);
    logic [63:0] prod;
    logic [63:0] f;
    prod = 64'd1 << 30;
    for (int unsigned k = 0; k < ROM_STAGES; k++) begin
      if (k < stages) begin
        f    = (64'd1 << 30) + ((2 * k <= 30) ? (64'd1 << (30 - 2 * k)) : 64'd0);
        prod = (prod * f + (64'd1 << 29)) >> 30;
      end
    end
    return sp_isqrt(sp_udiv(64'd1 << 62, prod) << 30);
  endfunction

endpackage

### hdl/asp_front.sv
module asp_front #(
  parameter int unsigned MAX_POINTS    = asp_pkg::MAX_POINTS_DEF,
  parameter int unsigned CORDIC_STAGES = asp_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [asp_pkg::CFG_W-1:0]    cfg_offset_i,
  input  logic signed [asp_pkg::CFG_W-1:0]    cfg_pitch_i,
  input  logic [asp_pkg::CFG_W-1:0]           cfg_step_i,
  input  logic                                in_valid_i,
  input  logic [asp_pkg::IDX_W-1:0]           in_index_i,
  output logic                                in_ready_o,
  output logic                                out_valid_o,
  output asp_pkg::red_t                       out_o,
  input  logic                                out_ready_i
);
  import asp_pkg::*;

  localparam int unsigned NS = 5;
  localparam int unsigned IdxLimit = (MAX_POINTS - 1 > IDX_MAX) ? IDX_MAX : MAX_POINTS - 1;
  localparam logic [IDX_W-1:0]         IdxTop = IDX_W'(IdxLimit);
  localparam logic signed [PROD_W-1:0] Gain   = PROD_W'(sp_gain_q31(CORDIC_STAGES));

  logic [NS:1] v_q;
  logic [NS:1] rdy;

  logic [TH16_W-1:0]       th1_q, th2_q, th3_q, th4_q, th5_q;
  logic [TH16_W-1:0]       th1_d;
  logic signed [R31_W-1:0] r31_q, r31_d;
  logic signed [R16_W-1:0] r16_q, r16_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [XW-1:0]    x0_q, x0_d;

  logic [IDX_W-1:0]         idx_c;
  logic signed [R31_W-1:0]  off_ext, pitch_ext, th_ext, r31_sum;
  logic signed [PROD_W-1:0] r16_ext, prod_rnd;

  always_comb begin
    rdy[NS] = !v_q[NS] || out_ready_i;
    for (int i = NS - 1; i >= 1; i--) begin
      rdy[i] = !v_q[i] || rdy[i+1];
    end
  end

  assign in_ready_o  = rdy[1];
  assign out_valid_o = v_q[NS];
  assign out_o.z     = {th5_q, 16'b0};
  assign out_o.x0    = x0_q;

  always_comb begin
    idx_c     = (in_index_i > IdxTop) ? IdxTop : in_index_i;
    th1_d     = TH16_W'(idx_c) * TH16_W'(cfg_step_i);

    off_ext   = R31_W'(cfg_offset_i);
    pitch_ext = R31_W'(cfg_pitch_i);
    th_ext    = R31_W'(th1_q);
    r31_d     = (off_ext <<< 16) + pitch_ext * th_ext;

    r31_sum   = r31_q + R31_W'(1 << 14);
    r16_d     = r31_sum[R31_W-1:15];

    r16_ext   = PROD_W'(r16_q);
    prod_d    = r16_ext * Gain;

    prod_rnd  = prod_q + PROD_W'(1 << 22);
    x0_d      = XW'($signed(prod_rnd[PROD_W-1:23]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = NS; i >= 2; i--) begin
        if (rdy[i]) v_q[i] <= v_q[i-1];
      end
      if (rdy[1]) v_q[1] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) th1_q <= th1_d;
    if (rdy[2]) begin
      th2_q <= th1_q;
      r31_q <= r31_d;
    end
    if (rdy[3]) begin
      th3_q <= th2_q;
      r16_q <= r16_d;
    end
    if (rdy[4]) begin
      th4_q  <= th3_q;
      prod_q <= prod_d;
    end
    if (rdy[5]) begin
      th5_q <= th4_q;
      x0_q  <= x0_d;
    end
  end

endmodule

### hdl/asp_reduce_cell.sv
module asp_reduce_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  asp_pkg::red_t in_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  output asp_pkg::red_t out_o,
  input  logic          out_ready_i
);
  import asp_pkg::*;

  // One binary digit of the quotient by 2*pi per cell.
  localparam logic [TW-1:0] Sub = TW'(TWO_PI_Q32 << SHIFT);

  logic        v_q;
  red_t        d_q, d_d;
  logic [TW:0] diff;
  logic        rdy;

  assign rdy         = !v_q || out_ready_i;
  assign in_ready_o  = rdy;
  assign out_valid_o = v_q;
  assign out_o       = d_q;

  always_comb begin
    diff  = {1'b0, in_i.z} - {1'b0, Sub};
    d_d   = in_i;
    if (!diff[TW]) d_d.z = diff[TW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (rdy) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy) d_q <= d_d;
  end

endmodule

### hdl/asp_cordic_cell.sv
module asp_cordic_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  asp_pkg::cord_t in_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  output asp_pkg::cord_t out_o,
  input  logic           out_ready_i
);
  import asp_pkg::*;

  localparam logic signed [ZW-1:0] Atan = ZW'(sp_atan_q32(STAGE));

  logic                 v_q;
  cord_t                d_q, d_d;
  logic signed [XW-1:0] dx, dy;
  logic                 rdy;

  assign rdy         = !v_q || out_ready_i;
  assign in_ready_o  = rdy;
  assign out_valid_o = v_q;
  assign out_o       = d_q;

  always_comb begin
    dx  = in_i.x >>> STAGE;
    dy  = in_i.y >>> STAGE;
    d_d = in_i;
    if (!in_i.z[ZW-1]) begin
      d_d.x = in_i.x - dy;
      d_d.y = in_i.y + dx;
      d_d.z = in_i.z - Atan;
    end else begin
      d_d.x = in_i.x + dy;
      d_d.y = in_i.y - dx;
      d_d.z = in_i.z + Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (rdy) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy) d_q <= d_d;
  end

endmodule

### hdl/archimedean_spiral_point_generator.sv
// Archimedean spiral vertex generator.
// Input stream (s_axis_*): one request per point index; the block answers each
// with one vertex on the output stream (m_axis_*): x and y in signed Q7.16
// and a clipped flag in tuser, set when either coordinate saturated.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_addr_i
// (0 offset, 1 pitch, 2 angle step); other indexes are dropped. Write only
// while no request is in flight.
// Pipeline from input handshake to output valid: five front stages for the angle
// and radius products, eight angle-reduction cells, one fold stage, one CORDIC
// cell per stage and one output register.
// Throughput: one vertex per cycle while m_axis_tready holds; every cell is
// one register stage. Stall: each cell holds its request while the next one is
// full and stalled, so bubbles collapse and new requests keep entering until the
// whole chain is full. Reset: all cells empty, registers back to offset 1638,
// pitch 1638 and step 6554; no clearing pass.
module archimedean_spiral_point_generator #(
  parameter int unsigned MAX_POINTS    = asp_pkg::MAX_POINTS_DEF,
  parameter int unsigned CORDIC_STAGES = asp_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  // Point index stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [9:0] point_index, rest zero
  // Vertex stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [23:0] coord_x, [47:24] coord_y
  output logic        m_axis_tuser    // [0] clipped
);
  import asp_pkg::*;

  localparam logic signed [ZW-1:0]   TwoPiZ  = ZW'(TWO_PI_Q32);
  localparam logic signed [ZW-1:0]   PiZ     = ZW'(PI_Q32);
  localparam logic signed [ZW-1:0]   HalfZ   = ZW'(HALF_PI_Q32);
  localparam logic signed [ZW-1:0]   FoldThr = TwoPiZ - HalfZ;
  // Angles in (pi, FoldThr) wrap by 2*pi, then turn by pi: net shift 2*pi - pi.
  localparam logic signed [ZW-1:0]   PiFar   = TwoPiZ - PiZ;
  localparam logic signed [SH_W-1:0] OutMax  = SH_W'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [SH_W-1:0] OutMin  = -SH_W'(1 << (OUT_W - 1));

  // Configuration registers
  logic signed [CFG_W-1:0] cfg_offset_q, cfg_pitch_q;
  logic [CFG_W-1:0]        cfg_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_offset_q <= OFFSET_RST;
      cfg_pitch_q  <= PITCH_RST;
      cfg_step_q   <= STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_OFFSET: cfg_offset_q <= cfg_wdata_i;
        REG_PITCH:  cfg_pitch_q  <= cfg_wdata_i;
        REG_STEP:   cfg_step_q   <= cfg_wdata_i;
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // Front: clamp, angle product, radius, gain pre-scale
  logic [RED_STEPS:0] red_v, red_rdy;
  red_t               red_d [RED_STEPS+1];

  asp_front #(
    .MAX_POINTS    (MAX_POINTS),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_offset_i (cfg_offset_q),
    .cfg_pitch_i  (cfg_pitch_q),
    .cfg_step_i   (cfg_step_q),
    .in_valid_i   (s_axis_tvalid),
    .in_index_i   (s_axis_tdata[IDX_W-1:0]),
    .in_ready_o   (s_axis_tready),
    .out_valid_o  (red_v[0]),
    .out_o        (red_d[0]),
    .out_ready_i  (red_rdy[0])
  );

  // Angle reduction modulo 2*pi, most significant quotient bit first
  for (genvar j = 0; j < RED_STEPS; j++) begin : g_red
    asp_reduce_cell #(
      .SHIFT (RED_STEPS - 1 - j)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (red_v[j]),
      .in_i        (red_d[j]),
      .in_ready_o  (red_rdy[j]),
      .out_valid_o (red_v[j+1]),
      .out_o       (red_d[j+1]),
      .out_ready_i (red_rdy[j+1])
    );
  end

  // Fold into [-pi/2, pi/2]; the far half flips the vector at the end
  logic [CORDIC_STAGES:0] cord_v, cord_rdy;
  cord_t                  cord_d [CORDIC_STAGES+1];

  logic                 fold_v_q;
  cord_t                fold_q, fold_d;
  logic signed [ZW-1:0] zs;
  logic                 le_half, le_pi, lt_thr;

  always_comb begin
    zs          = $signed({1'b0, red_d[RED_STEPS].z[ZW-2:0]});
    le_half     = zs <= HalfZ;
    le_pi       = zs <= PiZ;
    lt_thr      = zs < FoldThr;
    fold_d.x    = red_d[RED_STEPS].x0;
    fold_d.y    = '0;
    fold_d.neg  = !le_half && lt_thr;
    if (le_half) begin
      fold_d.z = zs;
    end else if (le_pi) begin
      fold_d.z = zs - PiZ;
    end else if (lt_thr) begin
      fold_d.z = zs - PiFar;
    end else begin
      fold_d.z = zs - TwoPiZ;
    end
  end

  assign red_rdy[RED_STEPS] = !fold_v_q || cord_rdy[0];
  assign cord_v[0]          = fold_v_q;
  assign cord_d[0]          = fold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_v_q <= 1'b0;
    end else if (red_rdy[RED_STEPS]) begin
      fold_v_q <= red_v[RED_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (red_rdy[RED_STEPS]) fold_q <= fold_d;
  end

  // Rotation-mode CORDIC, one micro-rotation per cell
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    asp_cordic_cell #(
      .STAGE (k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (cord_v[k]),
      .in_i        (cord_d[k]),
      .in_ready_o  (cord_rdy[k]),
      .out_valid_o (cord_v[k+1]),
      .out_o       (cord_d[k+1]),
      .out_ready_i (cord_rdy[k+1])
    );
  end

  // Output register: undo the fold, round Q.24 to Q.16, saturate
  logic                   m_valid_q;
  logic [OUT_W-1:0]       coord_x_q, coord_y_q, coord_x_d, coord_y_d;
  logic                   clip_q, clip_d;
  logic                   out_rdy;
  logic signed [XW:0]     sum_x, sum_y;
  logic signed [SH_W-1:0] sh_x, sh_y;
  cord_t                  fin;

  assign out_rdy                  = !m_valid_q || m_axis_tready;
  assign cord_rdy[CORDIC_STAGES]  = out_rdy;
  assign fin                      = cord_d[CORDIC_STAGES];

  always_comb begin
    if (fin.neg) begin
      sum_x = (XW+1)'(128) - (XW+1)'(fin.x);
      sum_y = (XW+1)'(128) - (XW+1)'(fin.y);
    end else begin
      sum_x = (XW+1)'(fin.x) + (XW+1)'(128);
      sum_y = (XW+1)'(fin.y) + (XW+1)'(128);
    end
    sh_x   = sum_x[XW:8];
    sh_y   = sum_y[XW:8];
    clip_d = 1'b0;
    if (sh_x > OutMax) begin
      coord_x_d = OutMax[OUT_W-1:0];
      clip_d    = 1'b1;
    end else if (sh_x < OutMin) begin
      coord_x_d = OutMin[OUT_W-1:0];
      clip_d    = 1'b1;
    end else begin
      coord_x_d = sh_x[OUT_W-1:0];
    end
    if (sh_y > OutMax) begin
      coord_y_d = OutMax[OUT_W-1:0];
      clip_d    = 1'b1;
    end else if (sh_y < OutMin) begin
      coord_y_d = OutMin[OUT_W-1:0];
      clip_d    = 1'b1;
    end else begin
      coord_y_d = sh_y[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_rdy) begin
      m_valid_q <= cord_v[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy) begin
      coord_x_q <= coord_x_d;
      coord_y_q <= coord_y_d;
      clip_q    <= clip_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {coord_y_q, coord_x_q};
  assign m_axis_tuser  = clip_q;

  `include "archimedean_spiral_point_generator_macros.svh"

  // An empty output register frees the whole chain, so the input must be open.
  `ASP_ASSERT_IMPLIES(a_ready_when_drained, !m_valid_q, s_axis_tready,
    "input stalled with empty output register")
  // Reduction leaves an angle below 2*pi.
  `ASP_ASSERT_IMPLIES(a_reduced_range, red_v[RED_STEPS],
    $signed({1'b0, red_d[RED_STEPS].z}) < $signed({1'b0, TW'(TWO_PI_Q32)}),
    "reduced angle not below 2*pi")
  // The CORDIC only ever sees angles within a quarter turn.
  `ASP_ASSERT_IMPLIES(a_fold_range, cord_v[0],
    (cord_d[0].z <= HalfZ) && (cord_d[0].z >= -HalfZ),
    "folded angle outside [-pi/2, pi/2]")
  // A taken vertex with nothing behind it leaves the output empty.
  `ASP_ASSERT_NEXT(a_out_drains, m_valid_q && m_axis_tready && !cord_v[CORDIC_STAGES],
    !m_valid_q, "output register kept a delivered vertex")

endmodule
